// File: design/atc_pkg.sv
// Shared types and field widths for the assembler token classifier.
package atc_pkg;

    localparam int CH_W    = 8;
    localparam int VALUE_W = 32;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // Per-character class flags, decoded once per item.
    typedef struct packed {
        logic       letter;
        logic       digit;
        logic       ident;
        logic       is_colon;
        logic       is_dot;
        logic       is_semi;
        logic       is_dollar;
        logic       is_pct;
        logic       is_quote;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       bin_ok;
    } char_class_t;

    // One classification result.
    typedef struct packed {
        logic               is_label_def;
        logic               is_mnemonic;
        logic               is_directive;
        logic               is_label_ref;
        logic               is_end_marker;
        logic               number_ok;
        logic [VALUE_W-1:0] number_value;
    } result_t;

endpackage

// File: design/atc_char_decode.sv
// Character decoder: classifies one byte and gives its digit value.
module atc_char_decode (
    input  logic [atc_pkg::CH_W-1:0] ch,
    output atc_pkg::char_class_t     cls
);
    import atc_pkg::*;

    localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CH_W-1:0] CH_PCT    = 8'h25;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h27;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CH_W-1:0] CH_0      = 8'h30;
    localparam logic [CH_W-1:0] CH_9      = 8'h39;
    localparam logic [CH_W-1:0] CH_1      = 8'h31;

    logic lower, upper, hex_lo, hex_up;

    always_comb begin
        lower  = ch inside {[8'h61:8'h7A]};
        upper  = ch inside {[8'h41:8'h5A]};
        hex_lo = ch inside {[8'h61:8'h66]};
        hex_up = ch inside {[8'h41:8'h46]};

        cls.letter    = lower | upper;
        cls.digit     = ch inside {[CH_0:CH_9]};
        cls.ident     = cls.letter | cls.digit | (ch == CH_UNDER);
        cls.is_colon  = (ch == CH_COLON);
        cls.is_dot    = (ch == CH_DOT);
        cls.is_semi   = (ch == CH_SEMI);
        cls.is_dollar = (ch == CH_DOLLAR);
        cls.is_pct    = (ch == CH_PCT);
        cls.is_quote  = (ch == CH_QUOTE);
        cls.bin_ok    = (ch == CH_0) | (ch == CH_1);
        cls.hex_ok    = cls.digit | hex_lo | hex_up;
        // a-f and A-F share low bits: value is low nibble plus 9
        if (cls.digit) begin
            cls.hex_val = ch[3:0];
        end else begin
            cls.hex_val = ch[3:0] + 4'd9;
        end
    end

endmodule

// File: design/atc_token_core.sv
// Token state: per-class tracking and number accumulation, one character a cycle while step_char is high.
module atc_token_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_char,
    input  logic                     step_end,
    input  logic [atc_pkg::CH_W-1:0] ch,
    input  atc_pkg::char_class_t     cls,
    output atc_pkg::result_t         result
);
    import atc_pkg::*;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_DEC   = 3'd1;
    localparam logic [2:0] MODE_HEX   = 3'd2;
    localparam logic [2:0] MODE_BIN   = 3'd3;
    localparam logic [2:0] MODE_QWAIT = 3'd4;
    localparam logic [2:0] MODE_QDONE = 3'd5;

    localparam logic [1:0] LD_PENDING = 2'd0;
    localparam logic [1:0] LD_IDENT   = 2'd1;
    localparam logic [1:0] LD_COLON   = 2'd2;
    localparam logic [1:0] LD_FAILED  = 2'd3;

    logic [1:0]         pos_reg, pos_next;
    logic [2:0]         mode_reg, mode_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               bad_reg, bad_next;
    logic [1:0]         ld_reg, ld_next;
    logic               letters_reg, letters_next;
    logic               dir_reg, dir_next;
    logic               ref_reg, ref_next;
    logic               semi_reg, semi_next;

    logic               first;
    logic               prefix;
    logic [2:0]         feed_mode;
    logic [2:0]         fed_mode;
    logic [VALUE_W-1:0] fed_acc;
    logic               fed_bad;
    logic               empty;
    logic               ok;

    assign first  = (pos_reg == 2'd0);
    assign prefix = cls.is_dollar | cls.is_pct | cls.is_quote;
    // first character that is no prefix is fed as a decimal digit
    assign feed_mode = first ? MODE_DEC : mode_reg;

    // number accumulator step
    always_comb begin
        fed_mode = feed_mode;
        fed_acc  = acc_reg;
        fed_bad  = bad_reg;
        case (feed_mode)
            MODE_DEC: begin
                if (cls.digit) begin
                    fed_acc = (acc_reg << 3) + (acc_reg << 1)
                              + {{(VALUE_W-4){1'b0}}, ch[3:0]};
                end else begin
                    fed_bad = 1'b1;
                end
            end
            MODE_HEX: begin
                if (cls.hex_ok) begin
                    fed_acc = {acc_reg[VALUE_W-5:0], cls.hex_val};
                end else begin
                    fed_bad = 1'b1;
                end
            end
            MODE_BIN: begin
                if (cls.bin_ok) begin
                    fed_acc = {acc_reg[VALUE_W-2:0], ch[0]};
                end else begin
                    fed_bad = 1'b1;
                end
            end
            MODE_QWAIT: begin
                fed_acc  = {{(VALUE_W-CH_W){1'b0}}, ch};
                fed_mode = MODE_QDONE;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        pos_next     = pos_reg;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        ld_next      = ld_reg;
        letters_next = letters_reg;
        dir_next     = dir_reg;
        ref_next     = ref_reg;
        semi_next    = semi_reg;
        if (step_end) begin
            pos_next     = 2'd0;
            mode_next    = MODE_NONE;
            acc_next     = '0;
            bad_next     = 1'b0;
            ld_next      = LD_PENDING;
            letters_next = 1'b1;
            dir_next     = 1'b0;
            ref_next     = 1'b0;
            semi_next    = 1'b0;
        end else if (step_char) begin
            if (pos_reg != 2'd3) begin
                pos_next = pos_reg + 2'd1;
            end
            if (first) begin
                ld_next      = (cls.letter | (cls.ident & !cls.digit)) ? LD_IDENT : LD_FAILED;
                letters_next = cls.letter;
                dir_next     = cls.is_dot;
                ref_next     = cls.ident & !cls.digit;
                semi_next    = cls.is_semi;
                if (cls.is_dollar) begin
                    mode_next = MODE_HEX;
                end else if (cls.is_pct) begin
                    mode_next = MODE_BIN;
                end else if (cls.is_quote) begin
                    mode_next = MODE_QWAIT;
                end
            end else begin
                if (ld_reg == LD_IDENT) begin
                    if (cls.is_colon) begin
                        ld_next = LD_COLON;
                    end else if (!cls.ident) begin
                        ld_next = LD_FAILED;
                    end
                end
                letters_next = letters_reg & cls.letter;
                dir_next     = dir_reg & cls.letter;
                ref_next     = ref_reg & cls.ident;
            end
            if (!(first && prefix)) begin
                mode_next = fed_mode;
                acc_next  = fed_acc;
                bad_next  = fed_bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 2'd0;
            mode_reg    <= MODE_NONE;
            acc_reg     <= '0;
            bad_reg     <= 1'b0;
            ld_reg      <= LD_PENDING;
            letters_reg <= 1'b1;
            dir_reg     <= 1'b0;
            ref_reg     <= 1'b0;
            semi_reg    <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            bad_reg     <= bad_next;
            ld_reg      <= ld_next;
            letters_reg <= letters_next;
            dir_reg     <= dir_next;
            ref_reg     <= ref_next;
            semi_reg    <= semi_next;
        end
    end

    // classification from the state left by the token
    assign empty = first;
    assign ok    = empty | !bad_reg;
    assign result.is_label_def  = (ld_reg == LD_COLON);
    assign result.is_mnemonic   = letters_reg;
    assign result.is_directive  = dir_reg;
    assign result.is_label_ref  = ref_reg;
    assign result.is_end_marker = empty | semi_reg;
    assign result.number_ok     = ok;
    assign result.number_value  = ok ? acc_reg : '0;

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_end |=> (pos_reg == 2'd0) && (acc_reg == '0) && !bad_reg)
        else $error("token state not cleared after end of token");

    a_quote_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        step_char && !step_end && first && cls.is_quote |=> (mode_reg == MODE_QWAIT))
        else $error("leading quote did not arm byte capture");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_end && first |-> result.is_mnemonic && result.is_end_marker
                              && result.number_ok && (result.number_value == '0))
        else $error("empty token classified wrongly");

endmodule

// File: design/asm_token_classifier.sv
// Top level: input register, token classifier and result register.
// Takes one token character per item and gives one classification item when
// an item with tlast high closes the token; that item's character is ignored.
// A character is registered, then its class decode and the accumulate step
// (shift and add into the 32-bit value) update the token state in the next
// cycle, so items are accepted back to back. The end item loads the result
// register as it leaves the input register; the input side stalls only while
// an end item waits behind a result not yet taken.
module asm_token_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [atc_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] ch
    input  logic                          s_tlast,   // token_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] is_label_def, [1] is_mnemonic, [2] is_directive, [3] is_label_ref,
    // [4] is_end_marker, [5] number_ok, [37:6] number_value, [39:38] zero
    output logic [atc_pkg::M_TDATA_W-1:0] m_tdata
);
    import atc_pkg::*;

    logic            in_valid_reg;
    logic [CH_W-1:0] in_ch_reg;
    logic            in_last_reg;
    logic            advance;
    logic            out_valid_reg;
    result_t         out_res_reg;
    char_class_t     cls;
    result_t         result;

    // an end item needs a free result slot; characters always move on
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_ch_reg   <= s_tdata[CH_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    atc_char_decode u_decode (
        .ch  (in_ch_reg),
        .cls (cls)
    );

    atc_token_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_char (advance && !in_last_reg),
        .step_end  (advance && in_last_reg),
        .ch        (in_ch_reg),
        .cls       (cls),
        .result    (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.number_value,
                       out_res_reg.number_ok,
                       out_res_reg.is_end_marker,
                       out_res_reg.is_label_ref,
                       out_res_reg.is_directive,
                       out_res_reg.is_mnemonic,
                       out_res_reg.is_label_def};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(advance && in_last_reg))
        else $error("pending result overwritten");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_res_reg.number_ok |-> (out_res_reg.number_value == '0))
        else $error("value not zero on bad literal");

    a_dir_mnem: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_res_reg.is_directive && out_res_reg.is_mnemonic))
        else $error("token both directive and mnemonic");

endmodule
